### rtl/ssd_pkg.sv
// package for the seven segment display controller
// holds input kind codes, the ascii font and reset constants; no dependencies
`timescale 1ns / 1ps
package ssd_pkg;

  localparam int DIGITS_DEFAULT = 8;
  localparam logic [15:0] IDLE_MASK_RESET = 16'hFFFF;
  localparam logic [15:0] STARTUP_RESET = 16'd500;

  typedef enum logic [2:0] {
    KIND_CHAR    = 3'd0,
    KIND_TICK    = 3'd1,
    KIND_RESTORE = 3'd2,
    KIND_BLANK   = 3'd3,
    KIND_ON      = 3'd4
  } kind_t;

  localparam logic [0:0] CFG_IDLE_MASK = 1'b0;
  localparam logic [0:0] CFG_STARTUP   = 1'b1;

  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_DOT   = 7'h2E;
  localparam logic [7:0] DOT_BIT    = 8'h80;

  function automatic logic [7:0] glyph(input logic [6:0] c);
    logic [7:0] g;
    g = 8'h00;
    case (c)
      7'h21: g = 8'h86; 7'h22: g = 8'h22; 7'h27: g = 8'h02; 7'h28: g = 8'h39;
      7'h29: g = 8'h0F; 7'h2C: g = 8'h80; 7'h2D: g = 8'h40; 7'h2E: g = 8'h80;
      7'h2F: g = 8'h52; 7'h30: g = 8'h3F; 7'h31: g = 8'h06; 7'h32: g = 8'h5B;
      7'h33: g = 8'h4F; 7'h34: g = 8'h66; 7'h35: g = 8'h6D; 7'h36: g = 8'h7D;
      7'h37: g = 8'h07; 7'h38: g = 8'h7F; 7'h39: g = 8'h6F; 7'h3A: g = 8'h09;
      7'h3B: g = 8'h48; 7'h3D: g = 8'h48; 7'h3F: g = 8'h08;
      7'h41, 7'h61: g = 8'h77; 7'h42, 7'h62: g = 8'h7C; 7'h43, 7'h63: g = 8'h39;
      7'h44, 7'h64: g = 8'h5E; 7'h45, 7'h65: g = 8'h79; 7'h46, 7'h66: g = 8'h71;
      7'h47, 7'h67: g = 8'h3D; 7'h48, 7'h68: g = 8'h76; 7'h49, 7'h69: g = 8'h30;
      7'h4A, 7'h6A: g = 8'h1E; 7'h4B, 7'h6B: g = 8'h72; 7'h4C, 7'h6C: g = 8'h38;
      7'h4D, 7'h6D: g = 8'h37; 7'h4E, 7'h6E: g = 8'h54; 7'h4F, 7'h6F: g = 8'h5C;
      7'h50, 7'h70: g = 8'h73; 7'h51, 7'h71: g = 8'h67; 7'h52, 7'h72: g = 8'h50;
      7'h53, 7'h73: g = 8'h6D; 7'h54, 7'h74: g = 8'h78; 7'h55, 7'h75: g = 8'h1C;
      7'h56, 7'h76: g = 8'h3E; 7'h57, 7'h77: g = 8'h6A; 7'h58, 7'h78: g = 8'h49;
      7'h59, 7'h79: g = 8'h6E; 7'h5A, 7'h7A: g = 8'h5B;
      7'h5B: g = 8'h39; 7'h5C: g = 8'h64; 7'h5D: g = 8'h0F; 7'h5E: g = 8'h23;
      7'h5F: g = 8'h08;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] seg_reset(input int idx);
    logic [7:0] v;
    case (idx)
      0: v = 8'hBF;
      1, 2: v = 8'h3F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### rtl/ssd_shifter.sv
// frame serializer: select bits then segment bits, lsb first
// depends on ssd_pkg
`timescale 1ns / 1ps
module ssd_shifter #(
  parameter int DIGITS = ssd_pkg::DIGITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [DIGITS-1:0]   sel,
  input  logic [7:0]          seg,
  output logic                busy,
  output logic                strobe,
  output logic                serial_bit,
  output logic                frame_end
);
  import ssd_pkg::*;

  localparam int FRAME = DIGITS + 8;
  localparam int CW = $clog2(FRAME + 1);

  logic [FRAME-1:0] sreg;
  logic [CW-1:0]    left;

  assign busy       = (left != '0);
  assign strobe     = busy;
  assign serial_bit = sreg[0];
  assign frame_end  = (left == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (load) begin
      left <= CW'(FRAME);
    end else if (busy) begin
      left <= left - CW'(1);
    end
    if (load) begin
      sreg <= {seg, sel};
    end else begin
      sreg <= sreg >> 1;
    end
  end
endmodule

### rtl/seven_segment_display_controller_top.sv
// top level of the seven segment display controller
// depends on ssd_pkg and ssd_shifter
`timescale 1ns / 1ps
// a tick frame reads the segment memory before loading the shifter; a blank loads it directly
// and sends two frames; busy stays high while they shift out; a string end walks up to
// 2*DIGITS text entries; restore copies all DIGITS saved entries; other items leave busy
// low and can follow every cycle
// reset restores the power-up segments through a sweep over every digit, busy high
// results come out as strobed serial bits and the receiver cannot stall
module seven_segment_display_controller_top #(
  parameter int DIGITS = ssd_pkg::DIGITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [6:0]  text_char,
  input  logic        char_last,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        strobe,
  output logic        serial_bit,
  output logic        frame_end
);
  import ssd_pkg::*;

  localparam int AW = $clog2(DIGITS);
  localparam int CW = $clog2(DIGITS + 1);
  localparam int PW = AW + 1;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_TREAD, S_TLOAD, S_SHIFT, S_BLANK2,
    S_CREAD, S_CWAIT, S_CSTEP, S_FWAIT, S_FSTEP, S_RREAD, S_RWRITE
  } state_t;

  state_t state;

  logic [15:0] idle_mask, countdown;
  logic [CW-1:0] text_count;
  logic [AW-1:0] scan_pos;
  logic [AW-1:0] init_ptr;  // power-up sweep position

  // text memory, conversion reads it back right to left
  logic [6:0] text_mem [DIGITS];
  logic [AW-1:0] t_raddr;
  logic [6:0] t_rdata;

  // segment and saved memories, one read and one write port each
  logic [7:0] seg_mem [DIGITS];
  logic [7:0] sav_mem [DIGITS];
  logic [AW-1:0] s_raddr, s_waddr;
  logic [7:0] s_rdata, v_rdata, s_wdata, v_wdata;
  logic s_we, v_we;

  // conversion state; the top bit of sl marks a walk past the left end
  logic [PW-1:0] cp;        // text position of the word walk
  logic [PW-1:0] sl;        // segment slot being written
  logic          seen, dot, clr;

  logic sh_load, sh_busy;
  logic [DIGITS-1:0] sh_sel;
  logic [7:0] sh_seg;
  logic blank_pend;

  ssd_shifter #(.DIGITS(DIGITS)) u_shift (
    .clk, .rst, .load(sh_load), .sel(sh_sel), .seg(sh_seg),
    .busy(sh_busy), .strobe, .serial_bit, .frame_end
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    t_rdata <= text_mem[t_raddr];
    s_rdata <= seg_mem[s_raddr];
    v_rdata <= sav_mem[s_raddr];
    if (s_we) seg_mem[s_waddr] <= s_wdata;
    if (v_we) sav_mem[s_waddr] <= v_wdata;
  end

  // text char as padded space when beyond the stored count
  logic [6:0] tch;
  assign tch = (CW'(t_raddr) < text_count) ? t_rdata : CHAR_SPACE;

  // segment byte of a word character, with a pending dot folded in
  logic [7:0] cbyte;
  assign cbyte = glyph(tch) | (dot ? DOT_BIT : 8'h00);

  // slot after this walk step: a dot takes no slot
  logic [PW-1:0] sl_step;
  assign sl_step = (tch == CHAR_DOT) ? sl : sl - PW'(1);

  logic [DIGITS-1:0] scan_sel;
  assign scan_sel = idle_mask[DIGITS-1:0]
                    & ~(DIGITS'(1) << (AW'(DIGITS - 1) - scan_pos));

  always_ff @(posedge clk) begin
    sh_load <= 1'b0;
    s_we    <= 1'b0;
    v_we    <= 1'b0;
    if (rst) begin
      state      <= S_INIT;
      idle_mask  <= IDLE_MASK_RESET;
      countdown  <= STARTUP_RESET;
      text_count <= '0;
      scan_pos   <= '0;
      init_ptr   <= '0;
      blank_pend <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDLE_MASK: idle_mask <= cfg_data;
          CFG_STARTUP: begin
            countdown <= cfg_data;
          end
          default: ;
        endcase
      end
      unique case (state)
        S_INIT: begin
          // sweep the power-up pattern into segments, zeros into the saved copy
          s_we    <= 1'b1;
          v_we    <= 1'b1;
          s_waddr <= init_ptr;
          s_wdata <= seg_reset(int'(init_ptr));
          v_wdata <= '0;
          if (init_ptr == AW'(DIGITS - 1)) state <= S_IDLE;
          else init_ptr <= init_ptr + AW'(1);
        end
        S_IDLE: begin
          if (start) begin
            case (kind)
              KIND_CHAR: begin
                if (text_char != '0 && text_count < CW'(DIGITS)) begin
                  text_mem[text_count[AW-1:0]] <= text_char;
                end
                if (text_char == '0 || char_last) begin
                  if (text_count != '0 || (text_char != '0)) begin
                    if (text_char != '0 && text_count < CW'(DIGITS))
                      text_count <= text_count + CW'(1);
                    state <= S_CREAD;
                  end
                end else if (text_char != '0 && text_count < CW'(DIGITS)) begin
                  text_count <= text_count + CW'(1);
                end
              end
              KIND_TICK: begin
                if (countdown > 16'd1) countdown <= countdown - 16'd1;
                else if (countdown == 16'd1) begin
                  s_raddr <= scan_pos;
                  state   <= S_TREAD;
                end
              end
              KIND_RESTORE: begin
                s_raddr <= '0;
                state   <= S_RREAD;
              end
              KIND_BLANK: begin
                countdown  <= '0;
                sh_sel     <= idle_mask[DIGITS-1:0];
                sh_seg     <= '0;
                sh_load    <= 1'b1;
                blank_pend <= 1'b1;
                state      <= S_SHIFT;
              end
              KIND_ON: countdown <= 16'd1;
              default: ;
            endcase
          end
        end
        S_TREAD: state <= S_TLOAD;
        S_TLOAD: begin
          sh_sel   <= scan_sel;
          sh_seg   <= s_rdata;
          sh_load  <= 1'b1;
          scan_pos <= (scan_pos == AW'(DIGITS - 1)) ? '0 : scan_pos + AW'(1);
          state    <= S_SHIFT;
        end
        S_SHIFT: begin
          if (!sh_load && !sh_busy) begin
            if (blank_pend) begin
              blank_pend <= 1'b0;
              sh_load    <= 1'b1;
              state      <= S_BLANK2;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_BLANK2: state <= S_SHIFT;
        S_RREAD: state <= S_RWRITE;
        S_RWRITE: begin
          // copy saved entry into segment memory, then read the next entry
          s_we    <= 1'b1;
          s_waddr <= s_raddr;
          s_wdata <= v_rdata;
          if (s_raddr == AW'(DIGITS - 1)) state <= S_IDLE;
          else begin
            s_raddr <= s_raddr + AW'(1);
            state   <= S_RREAD;
          end
        end
        S_CREAD: begin
          // start conversion at the rightmost position
          cp      <= PW'(DIGITS - 1);
          sl      <= PW'(DIGITS - 1);
          t_raddr <= AW'(DIGITS - 1);
          seen    <= 1'b0;
          dot     <= 1'b0;
          state   <= S_CWAIT;
        end
        S_CWAIT: state <= S_CSTEP;
        S_CSTEP: begin
          // word walk, one text entry per visit
          if (tch == CHAR_SPACE && seen) begin
            // a space after the word ends the walk
            clr <= 1'b1;
            if (sl[PW-1]) begin
              text_count <= '0;
              state      <= S_IDLE;
            end else begin
              t_raddr <= sl[AW-1:0];
              state   <= S_FWAIT;
            end
          end else begin
            if (tch != CHAR_SPACE) seen <= 1'b1;
            if (tch == CHAR_DOT) begin
              dot <= 1'b1;
            end else begin
              s_we    <= 1'b1;
              v_we    <= 1'b1;
              s_waddr <= sl[AW-1:0];
              s_wdata <= cbyte;
              v_wdata <= cbyte;
              dot     <= 1'b0;
            end
            sl <= sl_step;
            if (cp == '0) begin
              // walked past the left end
              clr <= 1'b1;
              if (sl_step[PW-1]) begin
                text_count <= '0;
                state      <= S_IDLE;
              end else begin
                t_raddr <= sl_step[AW-1:0];
                state   <= S_FWAIT;
              end
            end else begin
              cp      <= cp - PW'(1);
              t_raddr <= cp[AW-1:0] - AW'(1);
              state   <= S_CWAIT;
            end
          end
        end
        S_FWAIT: state <= S_FSTEP;
        S_FSTEP: begin
          // fill slots sl..0 from text: clear the word remainder, then glyphs
          s_we    <= 1'b1;
          v_we    <= 1'b1;
          s_waddr <= sl[AW-1:0];
          if (clr && tch != CHAR_SPACE) begin
            s_wdata <= '0;
            v_wdata <= '0;
          end else begin
            clr     <= 1'b0;
            s_wdata <= glyph(tch);
            v_wdata <= glyph(tch);
          end
          if (sl == '0) begin
            text_count <= '0;
            state      <= S_IDLE;
          end else begin
            sl      <= sl - PW'(1);
            t_raddr <= sl[AW-1:0] - AW'(1);
            state   <= S_FWAIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/seven_segment_display_controller_top_tb.sv
// testbench for the seven segment display controller top level
// predicts serial frames from strings, ticks and blank/on items; checks each strobed bit
// depends on ssd_pkg and the rtl of seven_segment_display_controller_top
`timescale 1ns / 1ps
module seven_segment_display_controller_top_tb;
  import ssd_pkg::*;

  localparam int NDIG = 8;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] ch;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic b;
    logic fe;
  } bit_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  kind;
  logic [6:0]  text_char;
  logic        char_last;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        strobe;
  logic        serial_bit;
  logic        frame_end;

  seven_segment_display_controller_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .text_char(text_char), .char_last(char_last), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .strobe(strobe),
    .serial_bit(serial_bit), .frame_end(frame_end)
  );

  // predictor state of the display
  logic [15:0] idle_mask;
  logic [7:0]  seg_mem [NDIG];
  logic [7:0]  saved_mem [NDIG];
  logic [6:0]  text_buf [NDIG];
  int          text_len;
  int          scan_pos;
  logic [15:0] countdown;

  cmd_t pending_cmds[$];
  bit_t expected_bits[$];
  int   fail_count;
  int   send_idle_pct;
  bit   driver_hold;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("seven_segment_display_controller_top_tb failed");
    $finish;
  end

  // font lookup written independently of the package
  function automatic logic [7:0] font_of(input logic [6:0] c);
    logic [7:0] tab [91];
    tab = '{8'h00,8'h86,8'h22,8'h00,8'h00,8'h00,8'h00,8'h02,8'h39,8'h0F,8'h00,8'h00,
            8'h80,8'h40,8'h80,8'h52,8'h3F,8'h06,8'h5B,8'h4F,8'h66,8'h6D,8'h7D,8'h07,
            8'h7F,8'h6F,8'h09,8'h48,8'h00,8'h48,8'h00,8'h08,8'h00,8'h77,8'h7C,8'h39,
            8'h5E,8'h79,8'h71,8'h3D,8'h76,8'h30,8'h1E,8'h72,8'h38,8'h37,8'h54,8'h5C,
            8'h73,8'h67,8'h50,8'h6D,8'h78,8'h1C,8'h3E,8'h6A,8'h49,8'h6E,8'h5B,8'h39,
            8'h64,8'h0F,8'h23,8'h08,8'h00,8'h77,8'h7C,8'h39,8'h5E,8'h79,8'h71,8'h3D,
            8'h76,8'h30,8'h1E,8'h72,8'h38,8'h37,8'h54,8'h5C,8'h73,8'h67,8'h50,8'h6D,
            8'h78,8'h1C,8'h3E,8'h6A,8'h49,8'h6E,8'h5B};
    if (c < 7'h20 || c > 7'h7A) return 8'h00;
    return tab[c - 7'h20];
  endfunction

  task automatic push_frame(input logic [15:0] sel, input logic [7:0] seg);
    for (int i = 0; i < NDIG; i++) expected_bits.push_back('{sel[i], 1'b0});
    for (int i = 0; i < 8; i++) expected_bits.push_back('{seg[i], i == 7});
  endtask

  // pad the string with spaces, fold dots of the rightmost word, font the rest
  task automatic render_text();
    logic [6:0] txt [NDIG];
    logic [7:0] seg [NDIG];
    logic [6:0] c;
    logic [7:0] dot;
    int cp, sl, i;
    bit seen;
    dot = 8'h00;
    seen = 0;
    for (i = 0; i < NDIG; i++) begin
      txt[i] = (i < text_len) ? text_buf[i] : CHAR_SPACE;
      seg[i] = 8'h00;
    end
    cp = NDIG - 1;
    sl = NDIG - 1;
    c = txt[NDIG - 1];
    while (cp >= 0) begin
      if (c != CHAR_SPACE) seen = 1;
      if (c == CHAR_DOT) begin
        dot = DOT_BIT;
      end else begin
        seg[sl] = font_of(c) | dot;
        dot = 8'h00;
        sl--;
      end
      cp--;
      if (cp < 0) break;
      c = txt[cp];
      if (c == CHAR_SPACE && seen) break;
    end
    i = sl;
    while (i >= 0 && txt[i] != CHAR_SPACE) begin
      seg[i] = 8'h00;
      i--;
    end
    while (i >= 0) begin
      seg[i] = font_of(txt[i]);
      i--;
    end
    for (i = 0; i < NDIG; i++) begin
      seg_mem[i] = seg[i];
      saved_mem[i] = seg[i];
    end
  endtask

  task automatic predict_cmd(input cmd_t cm);
    logic [15:0] sel;
    case (cm.kind)
      KIND_CHAR: begin
        if (cm.ch != 0 && text_len < NDIG) begin
          text_buf[text_len] = cm.ch;
          text_len++;
        end
        if (cm.ch == 0 || cm.last) begin
          if (text_len > 0) render_text();
          text_len = 0;
        end
      end
      KIND_TICK: begin
        if (countdown > 1) begin
          countdown--;
        end else if (countdown == 1) begin
          sel = idle_mask;
          sel[NDIG - 1 - scan_pos] = 1'b0;
          push_frame(sel, seg_mem[scan_pos]);
          scan_pos = (scan_pos + 1) % NDIG;
        end
      end
      KIND_RESTORE: begin
        for (int i = 0; i < NDIG; i++) seg_mem[i] = saved_mem[i];
      end
      KIND_BLANK: begin
        countdown = 16'd0;
        push_frame(idle_mask, 8'h00);
        push_frame(idle_mask, 8'h00);
      end
      KIND_ON: countdown = 16'd1;
      default: ;
    endcase
  endtask

  // driver: a transfer happens on an edge with start high and busy low
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) predict_cmd('{kind, text_char, char_last});
      if (pending_cmds.size() > 0 && !driver_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        cmd_t cm;
        cm = pending_cmds.pop_front();
        start <= 1'b1;
        kind <= cm.kind;
        text_char <= cm.ch;
        char_last <= cm.last;
      end else begin
        start <= 1'b0;
        kind <= 3'($urandom_range(7));
        text_char <= 7'($urandom);
        char_last <= 1'($urandom);
      end
    end
  end

  // monitor: compare each strobed bit with the oldest expectation
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_bits.size() == 0) begin
        $display("%0t: unexpected bit, expected none, actual bit %b end %b",
                 $time, serial_bit, frame_end);
        fail_count++;
      end else begin
        bit_t e;
        e = expected_bits.pop_front();
        if (serial_bit !== e.b) begin
          $display("%0t: serial_bit expected %b actual %b", $time, e.b, serial_bit);
          fail_count++;
        end
        if (frame_end !== e.fe) begin
          $display("%0t: frame_end expected %b actual %b", $time, e.fe, frame_end);
          fail_count++;
        end
      end
    end
  end

  task automatic add_cmd(input logic [2:0] k, input logic [6:0] c, input logic l);
    pending_cmds.push_back('{k, c, l});
  endtask

  task automatic add_text(input string s, input bit zero_end);
    for (int i = 0; i < s.len(); i++)
      add_cmd(KIND_CHAR, 7'(s[i]), !zero_end && i == s.len() - 1);
    if (zero_end) add_cmd(KIND_CHAR, 7'd0, 1'($urandom));
  endtask

  // wait until the driver has drained and every bit has come out
  task automatic drain();
    while (pending_cmds.size() > 0 || start) @(posedge clk);
    while (expected_bits.size() > 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDLE_MASK) begin
      idle_mask = val;
    end else begin
      countdown = val;
    end
  endtask

  // random string: mostly printable, some dots, some out-of-font codes
  task automatic add_random_text();
    int n;
    logic [6:0] c;
    n = $urandom_range(10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: c = CHAR_DOT;
        1: c = CHAR_SPACE;
        2: c = 7'($urandom_range(127, 1));
        default: c = 7'($urandom_range(7'h7A, 7'h21));
      endcase
      add_cmd(KIND_CHAR, c, i == n - 1 && $urandom_range(1));
    end
    add_cmd(KIND_CHAR, 7'd0, 1'($urandom));
  endtask

  task automatic add_random_phase(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 25) add_random_text();
      else if (r < 75) add_cmd(KIND_TICK, 7'($urandom), 1'($urandom));
      else if (r < 82) add_cmd(KIND_RESTORE, 7'($urandom), 1'($urandom));
      else if (r < 86) add_cmd(KIND_BLANK, 7'($urandom), 1'($urandom));
      else if (r < 95) add_cmd(KIND_ON, 7'($urandom), 1'($urandom));
      else add_cmd(3'($urandom_range(7, 5)), 7'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    fail_count = 0;
    send_idle_pct = 16;
    driver_hold = 1'b1;
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_TICK;
    text_char = 7'd0;
    char_last = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_IDLE_MASK;
    cfg_data = 16'd0;
    idle_mask = IDLE_MASK_RESET;
    countdown = STARTUP_RESET;
    text_len = 0;
    scan_pos = 0;
    for (int i = 0; i < NDIG; i++) begin
      seg_mem[i] = (i == 0) ? 8'hBF : (i < 3) ? 8'h3F : 8'h00;
      saved_mem[i] = 8'h00;
      text_buf[i] = 7'd0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // the reset sweep keeps busy high for a while
    repeat (40) @(posedge clk);
    driver_hold = 1'b0;

    // directed: short start delay, power-up pattern, then strings and controls
    write_reg(CFG_STARTUP, 16'd2);
    add_cmd(KIND_RESTORE, 7'd0, 1'b0);
    add_cmd(KIND_TICK, 7'd0, 1'b0);
    for (int i = 0; i < 3; i++) add_cmd(KIND_TICK, 7'd0, 1'b0);
    add_cmd(KIND_CHAR, 7'd0, 1'b1);             // empty string changes nothing
    add_text("12.3.4", 1'b0);                   // dots folded into digits
    add_text("ab cd.e", 1'b1);                  // only the rightmost word folds
    add_text("..........", 1'b0);               // long string, left end reached
    add_cmd(KIND_CHAR, 7'h7F, 1'b0);            // outside the font
    add_cmd(KIND_CHAR, 7'h01, 1'b1);
    add_cmd(KIND_RESTORE, 7'd0, 1'b0);
    for (int i = 0; i < 4; i++) add_cmd(KIND_TICK, 7'd0, 1'b0);
    add_cmd(KIND_BLANK, 7'd0, 1'b0);
    add_cmd(KIND_TICK, 7'd0, 1'b0);             // display off: no frame
    add_cmd(3'd7, 7'h7F, 1'b1);                 // unused kind
    add_cmd(KIND_ON, 7'd0, 1'b0);
    add_cmd(KIND_TICK, 7'd0, 1'b0);
    drain();

    write_reg(CFG_IDLE_MASK, 16'h0000);
    write_reg(CFG_STARTUP, 16'd0);              // stays off until on
    add_cmd(KIND_TICK, 7'd0, 1'b0);
    add_cmd(KIND_ON, 7'd0, 1'b0);
    add_random_phase(40);
    drain();

    // sender idles more in the second phase
    send_idle_pct = 50;
    write_reg(CFG_IDLE_MASK, 16'($urandom));
    write_reg(CFG_STARTUP, 16'hFFFF);
    add_cmd(KIND_ON, 7'd0, 1'b0);
    add_random_phase(40);
    drain();

    send_idle_pct = 0;
    write_reg(CFG_IDLE_MASK, 16'hFFFF);
    write_reg(CFG_STARTUP, 16'd3);
    add_random_phase(40);
    drain();

    if (fail_count == 0) begin
      $display("seven_segment_display_controller_top_tb passed");
    end else begin
      $display("seven_segment_display_controller_top_tb failed");
    end
    $finish;
  end

endmodule
